// File: design/sde_pkg.sv
// ----------------------------------------------------------------------------
// sde_pkg: shared constants and types for the set difference engine
// Holds the store depth, the derived widths, the request kind codes and the
// structs that pass between the sequencer, the stores and the top level.
// ----------------------------------------------------------------------------
package sde_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Write port of one store.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } st_wr_t;

    // One result handed from the sequencer to the output register.
    typedef struct packed {
        logic             push;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             empty;
        logic             ovf;
    } res_t;

endpackage

// File: design/sde_store.sv
// ----------------------------------------------------------------------------
// sde_store: element store of the set difference engine
// DEPTH words, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sde_store (
    input  logic                          clk,
    input  sde_pkg::st_wr_t               wr,
    input  logic [sde_pkg::IDX_W-1:0]     raddr,
    output logic [sde_pkg::VAL_W-1:0]     rdata
);

    logic [sde_pkg::VAL_W-1:0] mem [sde_pkg::DEPTH];
    logic [sde_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sde_seq.sv
// ----------------------------------------------------------------------------
// sde_seq: sequencer of the set difference engine
// Walks the stores one entry per cycle through a single equality comparator,
// for duplicate checks on loads and for the B lookups of a compute.
// ----------------------------------------------------------------------------
module sde_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_take,
    input  logic [sde_pkg::KIND_W-1:0]    req_kind,
    input  logic [sde_pkg::VAL_W-1:0]     req_value,
    output logic                          busy,
    output sde_pkg::st_wr_t               a_wr,
    output sde_pkg::st_wr_t               b_wr,
    output logic [sde_pkg::IDX_W-1:0]     a_raddr,
    output logic [sde_pkg::IDX_W-1:0]     b_raddr,
    input  logic [sde_pkg::VAL_W-1:0]     a_rdata,
    input  logic [sde_pkg::VAL_W-1:0]     b_rdata,
    input  logic                          out_free,
    output sde_pkg::res_t                 res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CNEXT  = 3'd1;
    localparam logic [2:0] S_CLAT   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_CEMIT  = 3'd4;
    localparam logic [2:0] S_CFIN   = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic [sde_pkg::CNT_W-1:0] a_cnt_reg, a_cnt_next;
    logic [sde_pkg::CNT_W-1:0] b_cnt_reg, b_cnt_next;
    logic                      ovf_reg, ovf_next;
    logic [sde_pkg::CNT_W-1:0] i_reg, i_next;
    logic [sde_pkg::CNT_W-1:0] j_reg, j_next;
    logic                      chk_reg, chk_next;
    logic                      tgt_reg, tgt_next;
    logic                      cmp_reg, cmp_next;
    logic                      prev_ok_reg, prev_ok_next;
    logic [sde_pkg::VAL_W-1:0] key_reg, key_next;
    logic [sde_pkg::VAL_W-1:0] prev_reg, prev_next;

    logic [sde_pkg::CNT_W-1:0] cnt_sel;
    logic [sde_pkg::VAL_W-1:0] rd_sel;
    logic                      hit;
    logic                      miss_done;

    assign cnt_sel   = tgt_reg ? b_cnt_reg : a_cnt_reg;
    assign rd_sel    = tgt_reg ? b_rdata : a_rdata;
    assign hit       = chk_reg && (rd_sel == key_reg);
    assign miss_done = !chk_reg && (j_reg >= cnt_sel);

    assign busy    = (state_reg != S_IDLE);
    assign a_raddr = (state_reg == S_CNEXT) ? i_reg[sde_pkg::IDX_W-1:0]
                                            : j_reg[sde_pkg::IDX_W-1:0];
    assign b_raddr = j_reg[sde_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        a_cnt_next   = a_cnt_reg;
        b_cnt_next   = b_cnt_reg;
        ovf_next     = ovf_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        chk_next     = chk_reg;
        tgt_next     = tgt_reg;
        cmp_next     = cmp_reg;
        prev_ok_next = prev_ok_reg;
        key_next     = key_reg;
        prev_next    = prev_reg;
        a_wr         = '0;
        b_wr         = '0;
        res          = '0;
        res.ovf      = ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    j_next   = '0;
                    chk_next = 1'b0;
                    key_next = req_value;
                    priority if (req_kind == sde_pkg::KIND_LOAD_A
                                 || req_kind == sde_pkg::KIND_LOAD_B)
                    begin
                        tgt_next   = (req_kind == sde_pkg::KIND_LOAD_B);
                        cmp_next   = 1'b0;
                        state_next = S_SCAN;
                    end
                    else if (req_kind == sde_pkg::KIND_COMPUTE)
                    begin
                        i_next       = '0;
                        prev_ok_next = 1'b0;
                        state_next   = S_CNEXT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_CNEXT:
            begin
                // The A entry at i is read here and shows up in S_CLAT.
                if (i_reg < a_cnt_reg)
                begin
                    state_next = S_CLAT;
                end
                else
                begin
                    state_next = S_CFIN;
                end
            end

            S_CLAT:
            begin
                key_next   = a_rdata;
                tgt_next   = 1'b1;
                cmp_next   = 1'b1;
                j_next     = '0;
                chk_next   = 1'b0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                priority if (hit)
                begin
                    if (cmp_reg)
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_CNEXT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (miss_done)
                begin
                    if (cmp_reg)
                    begin
                        if (prev_ok_reg)
                        begin
                            state_next = S_CEMIT;
                        end
                        else
                        begin
                            prev_next    = key_reg;
                            prev_ok_next = 1'b1;
                            i_next       = i_reg + 1'b1;
                            state_next   = S_CNEXT;
                        end
                    end
                    else
                    begin
                        if (cnt_sel == sde_pkg::CNT_FULL)
                        begin
                            ovf_next = 1'b1;
                        end
                        else if (tgt_reg)
                        begin
                            b_wr.we    = 1'b1;
                            b_wr.addr  = cnt_sel[sde_pkg::IDX_W-1:0];
                            b_wr.data  = key_reg;
                            b_cnt_next = b_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            a_wr.we    = 1'b1;
                            a_wr.addr  = cnt_sel[sde_pkg::IDX_W-1:0];
                            a_wr.data  = key_reg;
                            a_cnt_next = a_cnt_reg + 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (j_reg < cnt_sel)
                begin
                    j_next   = j_reg + 1'b1;
                    chk_next = 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                end
            end

            S_CEMIT:
            begin
                // A newer survivor exists, so the held one cannot be last.
                if (out_free)
                begin
                    res.push   = 1'b1;
                    res.value  = prev_reg;
                    prev_next  = key_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = S_CNEXT;
                end
            end

            S_CFIN:
            begin
                if (out_free)
                begin
                    res.push   = 1'b1;
                    res.last   = 1'b1;
                    res.empty  = !prev_ok_reg;
                    res.value  = prev_ok_reg ? prev_reg : '0;
                    a_cnt_next = '0;
                    b_cnt_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            a_cnt_reg   <= '0;
            b_cnt_reg   <= '0;
            ovf_reg     <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            chk_reg     <= 1'b0;
            tgt_reg     <= 1'b0;
            cmp_reg     <= 1'b0;
            prev_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            a_cnt_reg   <= a_cnt_next;
            b_cnt_reg   <= b_cnt_next;
            ovf_reg     <= ovf_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            chk_reg     <= chk_next;
            tgt_reg     <= tgt_next;
            cmp_reg     <= cmp_next;
            prev_ok_reg <= prev_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        prev_reg <= prev_next;
    end

endmodule

// File: design/set_difference_engine.sv
// Load request: the chosen store is scanned for the value, which is appended unless present or the store is full.
// Compute request: each A entry is looked up in store B; an output stall holds the sequencer while it emits.
// Rate is set by the one comparator, which checks one stored entry per clock.
// Requests are taken one at a time; a new request is accepted only when the sequencer is idle.
// Reset (rst_n, asynchronous) empties both stores, clears overflow and drops any result.
// ----------------------------------------------------------------------------
// set_difference_engine: set difference A \ B over two small stores
// Loads fill store A or store B with distinct signed 32-bit values; a compute
// request emits, in A's order, every A value absent from B (or one empty-flagged result if none), then empties both.
// ----------------------------------------------------------------------------
module set_difference_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sde_pkg::KIND_W-1:0]        kind,
    input  logic signed [sde_pkg::VAL_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sde_pkg::VAL_W-1:0]  value_res,
    output logic                              last,
    output logic                              empty_res,
    output logic                              overflow
);

    sde_pkg::st_wr_t               a_wr;
    sde_pkg::st_wr_t               b_wr;
    logic [sde_pkg::IDX_W-1:0]     a_raddr;
    logic [sde_pkg::IDX_W-1:0]     b_raddr;
    logic [sde_pkg::VAL_W-1:0]     a_rdata;
    logic [sde_pkg::VAL_W-1:0]     b_rdata;
    sde_pkg::res_t                 res;
    logic                          busy;
    logic                          req_take;
    logic                          out_free;

    // Output register. It is free when empty or when its result leaves
    // this cycle, so the sequencer can refill it without a bubble.
    logic                          out_valid_reg;
    logic [sde_pkg::VAL_W-1:0]     out_value_reg;
    logic                          out_last_reg;
    logic                          out_empty_reg;
    logic                          out_ovf_reg;

    // The input side is open only while the sequencer is idle.
    assign in_stall = busy;
    assign req_take = in_valid && !busy;
    assign out_free = !out_valid_reg || !out_stall;

    sde_store u_store_a (
        .clk   (clk),
        .wr    (a_wr),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    sde_store u_store_b (
        .clk   (clk),
        .wr    (b_wr),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    sde_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_take  (req_take),
        .req_kind  (kind),
        .req_value (value),
        .busy      (busy),
        .a_wr      (a_wr),
        .b_wr      (b_wr),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .out_free  (out_free),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The sequencer pushes only when the register is free, so the payload
    // holds steady for as long as the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            out_value_reg <= res.value;
            out_last_reg  <= res.last;
            out_empty_reg <= res.empty;
            out_ovf_reg   <= res.ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_res = out_value_reg;
    assign last      = out_last_reg;
    assign empty_res = out_empty_reg;
    assign overflow  = out_ovf_reg;

endmodule
